// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the table logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is applied.
`define AST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds while reset is applied.
`define AST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/ast_pkg.sv =====
`timescale 1ns / 1ps

package ast_pkg;

  // Default number of table slots.
  localparam int TableDepth = 64;

  localparam int AddrWidth = 32;
  localparam int SizeWidth = 32;

  // Request function codes.
  typedef enum logic [1:0] {
    FUNC_RECORD  = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_CLEAR   = 2'd2
  } func_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  // One request as it enters the block.
  typedef struct packed {
    logic [1:0]           func;
    logic [AddrWidth-1:0] addr;
    logic [SizeWidth-1:0] size;
  } req_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [SizeWidth-1:0] found_size;
    logic                 found;
    logic                 full_res;
  } res_t;

  // Contents of one slot, handed from a cell to its lower neighbor.
  typedef struct packed {
    logic [AddrWidth-1:0] addr;
    logic [SizeWidth-1:0] size;
    logic                 vld;
  } entry_t;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                 cmp_en;
    logic                 rec_en;
    logic                 clr_en;
    logic [AddrWidth-1:0] addr;
    logic [SizeWidth-1:0] size;
  } cell_cmd_t;

endpackage

// ===== rtl/core/ast_cell.sv =====
`timescale 1ns / 1ps

module ast_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ast_pkg::cell_cmd_t  cmd_i,
  input  logic                shift_i,
  input  logic                lower_vld_i,
  input  ast_pkg::entry_t     upper_i,
  output ast_pkg::entry_t     entry_o,
  output logic                match_o
);

  logic [ast_pkg::AddrWidth-1:0] addr_q, addr_d;
  logic [ast_pkg::SizeWidth-1:0] size_q, size_d;
  logic                          vld_q, vld_d;
  logic                          match_q, match_d;

  // Compare phase: note whether this slot holds the requested address.
  assign match_d = cmd_i.cmp_en ? (vld_q && (addr_q == cmd_i.addr)) : match_q;

  // Update phase: clear, fill the first free slot, or take the upper neighbor's entry.
  always_comb begin
    addr_d = addr_q;
    size_d = size_q;
    vld_d  = vld_q;
    priority if (cmd_i.clr_en) begin
      vld_d = 1'b0;
    end else if (cmd_i.rec_en && !vld_q && lower_vld_i) begin
      addr_d = cmd_i.addr;
      size_d = cmd_i.size;
      vld_d  = 1'b1;
    end else if (shift_i) begin
      addr_d = upper_i.addr;
      size_d = upper_i.size;
      vld_d  = upper_i.vld;
    end
  end

  // Slot payload carries no reset.
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    size_q <= size_d;
  end

  // Valid and match flags are control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      match_q <= 1'b0;
    end else begin
      vld_q   <= vld_d;
      match_q <= match_d;
    end
  end

  assign entry_o.addr = addr_q;
  assign entry_o.size = size_q;
  assign entry_o.vld  = vld_q;
  assign match_o      = match_q;

endmodule

// ===== rtl/core/ast_pick.sv =====
`timescale 1ns / 1ps

module ast_pick #(
  parameter int Depth = ast_pkg::TableDepth
) (
  input  logic                                    rel_en_i,
  input  logic [Depth-1:0]                        match_i,
  input  logic [Depth-1:0][ast_pkg::SizeWidth-1:0] size_i,
  output logic [Depth-1:0]                        shift_o,
  output logic                                    hit_o,
  output logic [ast_pkg::SizeWidth-1:0]           size_o
);

  logic [Depth-1:0] above;
  logic [Depth-1:0] sel;

  // A slot is the newest match when it matches and no newer slot does.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      above[i] = |(match_i >> (i + 1));
      sel[i]   = match_i[i] && !above[i];
    end
  end

  assign hit_o = |match_i;

  // The picked slot and every newer slot move down by one.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      shift_o[i] = rel_en_i && hit_o && !above[i];
    end
  end

  // Size of the picked slot; the select vector is one-hot or empty.
  always_comb begin
    size_o = '0;
    for (int i = 0; i < Depth; i++) begin
      size_o = size_o | (size_i[i] & {ast_pkg::SizeWidth{sel[i]}});
    end
  end

endmodule

// ===== rtl/core/allocation_size_table.sv =====
`timescale 1ns / 1ps
// A request accepted while idle passes through the compare and update steps of the cell
// row; the result strobe and payload are registered from the update step.
// A new request is accepted only while idle, so each request is through the compare and
// update steps of the cell row before the next one is taken; busy is high in those steps.
// Reset empties the table at once through the per-slot valid flags; no sweep is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "assert_macros.svh"

module allocation_size_table #(
  parameter int TABLE_DEPTH = ast_pkg::TableDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ast_pkg::req_t req_i,
  output logic          done_o,
  output ast_pkg::res_t res_o
);

  ast_pkg::state_e    state_q, state_d;
  ast_pkg::req_t      req_q;
  ast_pkg::cell_cmd_t cmd;
  ast_pkg::res_t      res_q, res_d;
  logic               done_q, done_d;
  logic               accept;
  logic               rel_en;
  logic               hit;
  logic [ast_pkg::SizeWidth-1:0] hit_size;

  ast_pkg::entry_t                            ent [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]                     match;
  logic [TABLE_DEPTH-1:0]                     vld;
  logic [TABLE_DEPTH-1:0]                     shift;
  logic [TABLE_DEPTH-1:0][ast_pkg::SizeWidth-1:0] sizes;

  assign busy   = (state_q != ast_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ast_pkg::ST_IDLE: if (accept) state_d = ast_pkg::ST_CMP;
      ast_pkg::ST_CMP:  state_d = ast_pkg::ST_UPD;
      ast_pkg::ST_UPD:  state_d = ast_pkg::ST_IDLE;
      default:          state_d = ast_pkg::ST_IDLE;
    endcase
  end

  // Commands to the cell row.
  always_comb begin
    cmd.cmp_en = (state_q == ast_pkg::ST_CMP);
    cmd.rec_en = (state_q == ast_pkg::ST_UPD) && (req_q.func == ast_pkg::FUNC_RECORD);
    cmd.clr_en = (state_q == ast_pkg::ST_UPD) && (req_q.func == ast_pkg::FUNC_CLEAR);
    cmd.addr   = req_q.addr;
    cmd.size   = req_q.size;
    rel_en     = (state_q == ast_pkg::ST_UPD) && (req_q.func == ast_pkg::FUNC_RELEASE);
  end

  // Result formed during the update step.
  always_comb begin
    res_d  = '0;
    done_d = (state_q == ast_pkg::ST_UPD);
    unique case (req_q.func)
      ast_pkg::FUNC_RECORD: begin
        res_d.full_res = vld[TABLE_DEPTH-1];
      end
      ast_pkg::FUNC_RELEASE: begin
        res_d.found      = hit;
        res_d.found_size = hit_size;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    res_q <= res_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ast_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Row of slot cells, oldest at index zero.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ast_pkg::entry_t upper;
    logic            lower_vld;

    if (i == TABLE_DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = ent[i+1];
    end

    if (i == 0) begin : g_bottom
      assign lower_vld = 1'b1;
    end else begin : g_upper
      assign lower_vld = ent[i-1].vld;
    end

    ast_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .shift_i     (shift[i]),
      .lower_vld_i (lower_vld),
      .upper_i     (upper),
      .entry_o     (ent[i]),
      .match_o     (match[i])
    );

    assign vld[i]   = ent[i].vld;
    assign sizes[i] = ent[i].size;
  end

  // Newest-match selection and removal control.
  ast_pick #(
    .Depth (TABLE_DEPTH)
  ) u_pick (
    .rel_en_i (rel_en),
    .match_i  (match),
    .size_i   (sizes),
    .shift_o  (shift),
    .hit_o    (hit),
    .size_o   (hit_size)
  );

  // Valid slots always form a packed run starting at slot zero.
  `AST_ASSERT(a_packed, (((vld >> 1) & ~vld) == '0), "valid slots not packed")
  // A result strobe follows only an update step.
  `AST_ASSERT(a_done_after_upd, (done_o |-> $past(state_q == ast_pkg::ST_UPD)), "stray result")
  // A result never reports both a match and a full table.
  `AST_ASSERT(a_res_excl, (done_o |-> !(res_o.found && res_o.full_res)), "found and full")
  // An accepted request keeps the block busy in the next cycle.
  `AST_ASSERT(a_busy_after_start, (accept |=> busy), "not busy after request")

endmodule
